>>> src/oversampled_quadratic_sensor_calibrator_assert.svh
// Assertion macros used by the calibrator top level.
`ifndef OVERSAMPLED_QUADRATIC_SENSOR_CALIBRATOR_ASSERT_SVH
`define OVERSAMPLED_QUADRATIC_SENSOR_CALIBRATOR_ASSERT_SVH

// Checks a property on every rising edge of clk outside reset.
`define OQSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that post holds in the cycle after pre.
`define OQSC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> src/oqsc_pkg.sv
// Shared widths, constants, register indexes and types of the calibrator.
`timescale 1ns / 1ps

package oqsc_pkg;

	localparam int VAL_W      = 12;
	localparam int SUM_W      = 20;
	localparam int AVG_W      = 13;
	localparam int PCT_W      = 15;
	localparam int OFF_W      = 24;
	localparam int COEF_W     = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	localparam int SAMPLES_DEF = 16;

	localparam int DIVD_W    = 24;
	localparam int DIVS_W    = 12;
	localparam int DIV_CNT_W = $clog2(DIVD_W);

	localparam int ACC_W      = 60;
	localparam int MUL_CNT_W  = $clog2(VAL_W);
	localparam int LIN_SHIFT  = 12;
	localparam int OFF_SHIFT  = 24;
	localparam int FRAC_SHIFT = 24;

	localparam logic [DIVS_W-1:0] RAW_FULL_MV   = 12'd3300;
	localparam logic [DIVS_W-1:0] RAW_FULL_CODE = 12'd4095;
	localparam logic [PCT_W-1:0]  MOIST_FULL    = 15'd25600;

	localparam logic [CFG_IDX_W-1:0] REG_FAULT_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAULT_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_SQ    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_LIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_OFF   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SAFE_LOW   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SAFE_HIGH  = 3'd6;

	localparam logic [VAL_W-1:0] FAULT_LOW_RST  = 12'd100;
	localparam logic [VAL_W-1:0] FAULT_HIGH_RST = 12'd3200;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

>>> src/oqsc_ifs.sv
// Valid/ready channel interfaces for samples and readings.
`timescale 1ns / 1ps

interface oqsc_sample_if;
	import oqsc_pkg::*;

	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] sample_value;
	logic             sample_is_mv;
	logic             read_failed;

	modport source (output valid, output sample_value, output sample_is_mv,
		output read_failed, input ready);
	modport sink (input valid, input sample_value, input sample_is_mv,
		input read_failed, output ready);
endinterface

interface oqsc_reading_if;
	import oqsc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    fault;
	logic signed [AVG_W-1:0] average_mv;
	logic [PCT_W-1:0]        moisture_pct;
	logic                    in_safe_window;

	modport source (output valid, output fault, output average_mv, output moisture_pct,
		output in_safe_window, input ready);
	modport sink (input valid, input fault, input average_mv, input moisture_pct,
		input in_safe_window, output ready);
endinterface

>>> src/oqsc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module oqsc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [oqsc_pkg::DIVD_W-1:0]   dividend,
	input  logic [oqsc_pkg::DIVS_W-1:0]   divisor,
	output oqsc_pkg::unit_sts_t           sts,
	output logic [oqsc_pkg::DIVS_W-1:0]   quotient
);
	import oqsc_pkg::*;

	logic [DIVD_W-1:0]    quo_q;
	logic [DIVS_W-1:0]    rem_q;
	logic [DIVS_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIVS_W:0]      trial;
	logic [DIVS_W:0]      diff;
	logic                 ge;

	always_comb begin
		trial = {rem_q, quo_q[DIVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q[DIVS_W-1:0];

endmodule

>>> src/oqsc_mul.sv
// Bit-serial shift-add multiplier with a preloaded addend.
`timescale 1ns / 1ps

module oqsc_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [oqsc_pkg::ACC_W-1:0] x,
	input  logic [oqsc_pkg::VAL_W-1:0]        m,
	input  logic signed [oqsc_pkg::ACC_W-1:0] addend,
	output oqsc_pkg::unit_sts_t               sts,
	output logic signed [oqsc_pkg::ACC_W-1:0] product
);
	import oqsc_pkg::*;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] x_q;
	logic [VAL_W-1:0]        m_q;
	logic [MUL_CNT_W-1:0]    cnt_q;
	logic                    busy_q;
	logic                    done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(VAL_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= addend;
			x_q   <= x;
			m_q   <= m;
		end else if (busy_q) begin
			if (m_q[0]) begin
				acc_q <= acc_q + x_q;
			end
			x_q <= x_q <<< 1;
			m_q <= m_q >> 1;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign product  = acc_q;

endmodule

>>> src/oversampled_quadratic_sensor_calibrator.sv
// Top level: sample averaging, fault check and quadratic moisture calibration.
//
//   Channel    Role   Carries
//   sample     sink   sample_value, sample_is_mv, read_failed
//   reading    source fault, average_mv, moisture_pct, in_safe_window
//   cfg_*      write  register index and data, no read-back
//
// A millivolt sample is accumulated directly; a raw code first runs the serial divider.
// The sample that closes a burst then runs the divider for the average, the multiplier
// in S_MUL1 and S_MUL2 for the quadratic, and the emit state.
// A faulted average skips the multiplier; a failed read goes from idle straight to emit.
// One sample is in work at a time; a finished reading waits in the output register.
// Reset clears the running sum and count and loads the register defaults.
`timescale 1ns / 1ps

`include "oversampled_quadratic_sensor_calibrator_assert.svh"

module oversampled_quadratic_sensor_calibrator #(
	parameter int SAMPLES_PER_READING = oqsc_pkg::SAMPLES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [oqsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [oqsc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	oqsc_sample_if.sink                       sample,
	oqsc_reading_if.source                    reading
);
	import oqsc_pkg::*;

	localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_CONV = 7'b0000010,
		S_ACC  = 7'b0000100,
		S_AVG  = 7'b0001000,
		S_MUL1 = 7'b0010000,
		S_MUL2 = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	state_t state_q;

	logic [VAL_W-1:0]         fault_low_q;
	logic [VAL_W-1:0]         fault_high_q;
	logic signed [COEF_W-1:0] coef_sq_q;
	logic signed [COEF_W-1:0] coef_lin_q;
	logic signed [OFF_W-1:0]  coef_off_q;
	logic [PCT_W-1:0]         safe_low_q;
	logic [PCT_W-1:0]         safe_high_q;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] mv_q;
	logic [VAL_W-1:0] avg_q;

	logic                    res_fault_q;
	logic signed [AVG_W-1:0] res_avg_q;
	logic [PCT_W-1:0]        res_moist_q;
	logic                    res_safe_q;

	logic                    out_valid_q;
	logic                    out_fault_q;
	logic signed [AVG_W-1:0] out_avg_q;
	logic [PCT_W-1:0]        out_moist_q;
	logic                    out_safe_q;

	logic                    accept;
	logic                    burst_end;
	logic [SUM_W-1:0]        sum_next;
	logic                    div_start;
	logic [DIVD_W-1:0]       div_dividend;
	logic [DIVS_W-1:0]       div_divisor;
	logic [DIVS_W-1:0]       div_quo;
	unit_sts_t               div_sts;
	logic                    mul_start;
	logic signed [ACC_W-1:0] mul_x;
	logic [VAL_W-1:0]        mul_m;
	logic signed [ACC_W-1:0] mul_addend;
	logic signed [ACC_W-1:0] mul_prod;
	unit_sts_t               mul_sts;
	logic                    avg_fault;
	logic [ACC_W-FRAC_SHIFT-1:0] whole;
	logic [PCT_W-1:0]        moist;
	logic                    out_free;

	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign sum_next     = sum_q + SUM_W'(mv_q);
	assign burst_end    = (cnt_q == CNT_W'(SAMPLES_PER_READING - 1));
	assign avg_fault    = (div_quo < fault_low_q) || (div_quo > fault_high_q);
	assign out_free     = !out_valid_q || reading.ready;

	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIVD_W'(sum_next);
		div_divisor  = DIVS_W'(SAMPLES_PER_READING);
		if (state_q == S_IDLE) begin
			div_start    = accept && !sample.read_failed && !sample.sample_is_mv;
			div_dividend = DIVD_W'(sample.sample_value) * DIVD_W'(RAW_FULL_MV);
			div_divisor  = RAW_FULL_CODE;
		end else if (state_q == S_ACC) begin
			div_start = burst_end;
		end
	end

	always_comb begin
		mul_start  = 1'b0;
		mul_x      = ACC_W'(coef_sq_q);
		mul_m      = div_quo;
		mul_addend = ACC_W'(coef_lin_q) <<< LIN_SHIFT;
		if (state_q == S_AVG) begin
			mul_start = div_sts.done && !avg_fault;
		end else if (state_q == S_MUL1) begin
			mul_start  = mul_sts.done;
			mul_x      = mul_prod;
			mul_m      = avg_q;
			mul_addend = ACC_W'(coef_off_q) <<< OFF_SHIFT;
		end
	end

	always_comb begin
		whole = mul_prod[ACC_W-1:FRAC_SHIFT];
		if (mul_prod[ACC_W-1]) begin
			moist = '0;
		end else if (whole > (ACC_W - FRAC_SHIFT)'(MOIST_FULL)) begin
			moist = MOIST_FULL;
		end else begin
			moist = whole[PCT_W-1:0];
		end
	end

	oqsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.sts      (div_sts),
		.quotient (div_quo)
	);

	oqsc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.x       (mul_x),
		.m       (mul_m),
		.addend  (mul_addend),
		.sts     (mul_sts),
		.product (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_low_q  <= FAULT_LOW_RST;
			fault_high_q <= FAULT_HIGH_RST;
			coef_sq_q    <= '0;
			coef_lin_q   <= '0;
			coef_off_q   <= '0;
			safe_low_q   <= '0;
			safe_high_q  <= MOIST_FULL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FAULT_LOW:  fault_low_q  <= cfg_wdata[VAL_W-1:0];
				REG_FAULT_HIGH: fault_high_q <= cfg_wdata[VAL_W-1:0];
				REG_COEF_SQ:    coef_sq_q    <= cfg_wdata[COEF_W-1:0];
				REG_COEF_LIN:   coef_lin_q   <= cfg_wdata[COEF_W-1:0];
				REG_COEF_OFF:   coef_off_q   <= cfg_wdata[OFF_W-1:0];
				REG_SAFE_LOW:   safe_low_q   <= cfg_wdata[PCT_W-1:0];
				REG_SAFE_HIGH:  safe_high_q  <= cfg_wdata[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (reading.valid && reading.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (sample.read_failed) begin
							sum_q   <= '0;
							cnt_q   <= '0;
							state_q <= S_EMIT;
						end else if (sample.sample_is_mv) begin
							state_q <= S_ACC;
						end else begin
							state_q <= S_CONV;
						end
					end
				end
				S_CONV: begin
					if (div_sts.done) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (burst_end) begin
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_AVG;
					end else begin
						sum_q   <= sum_next;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_AVG: begin
					if (div_sts.done) begin
						state_q <= avg_fault ? S_EMIT : S_MUL1;
					end
				end
				S_MUL1: begin
					if (mul_sts.done) begin
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (mul_sts.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mv_q        <= sample.sample_value;
			res_fault_q <= 1'b1;
			res_avg_q   <= '1;
			res_moist_q <= '0;
			res_safe_q  <= 1'b0;
		end
		if (state_q == S_CONV && div_sts.done) begin
			mv_q <= div_quo;
		end
		if (state_q == S_AVG && div_sts.done) begin
			avg_q       <= div_quo;
			res_fault_q <= avg_fault;
			res_avg_q   <= {1'b0, div_quo};
			res_moist_q <= '0;
			res_safe_q  <= 1'b0;
		end
		if (state_q == S_MUL2 && mul_sts.done) begin
			res_moist_q <= moist;
			res_safe_q  <= (moist >= safe_low_q) && (moist <= safe_high_q);
		end
		if (state_q == S_EMIT && out_free) begin
			out_fault_q <= res_fault_q;
			out_avg_q   <= res_avg_q;
			out_moist_q <= res_moist_q;
			out_safe_q  <= res_safe_q;
		end
	end

	assign reading.valid          = out_valid_q;
	assign reading.fault          = out_fault_q;
	assign reading.average_mv     = out_avg_q;
	assign reading.moisture_pct   = out_moist_q;
	assign reading.in_safe_window = out_safe_q;

	`OQSC_ASSERT(a_fault_zero, (reading.valid && reading.fault) |-> (reading.moisture_pct == '0 && !reading.in_safe_window), "Faulted item carries moisture or window flag")
	`OQSC_ASSERT_NEXT(a_fail_clears, accept && sample.read_failed, sum_q == '0 && cnt_q == '0, "Read failure did not restart the burst")
	`OQSC_ASSERT(a_idle_quiet, (state_q == S_IDLE) |-> (!div_sts.busy && !mul_sts.busy), "Arithmetic unit busy while idle")
	`OQSC_ASSERT(a_neg_avg_fault, (reading.valid && reading.average_mv == '1) |-> reading.fault, "Negative average without fault")

endmodule

>>> bench/oqsc_reading_checker.sv
// Checker that predicts each calibrated reading from the accepted samples and compares it.
`timescale 1ns / 1ps

module oqsc_reading_checker #(
	parameter int SAMPLES_PER_READING = oqsc_pkg::SAMPLES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [oqsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [oqsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	oqsc_sample_if                          sample_mon,
	oqsc_reading_if                         reading_mon,
	output int                              readings_pending,
	output int                              error_count
);
	import oqsc_pkg::*;

	typedef struct packed {
		logic                    fault;
		logic signed [AVG_W-1:0] average_mv;
		logic [PCT_W-1:0]        moisture_pct;
		logic                    in_safe_window;
	} reading_t;

	logic [VAL_W-1:0]         fault_low;
	logic [VAL_W-1:0]         fault_high;
	logic signed [COEF_W-1:0] coef_sq;
	logic signed [COEF_W-1:0] coef_lin;
	logic signed [OFF_W-1:0]  coef_off;
	logic [PCT_W-1:0]         safe_low;
	logic [PCT_W-1:0]         safe_high;
	logic [SUM_W-1:0]         mv_sum;
	logic [7:0]               taken;
	reading_t                 expected_readings[$];
	int                       mismatches = 0;

	assign error_count = mismatches;

	function automatic logic [VAL_W-1:0] sample_mv(input logic [VAL_W-1:0] value,
		input logic is_mv);
		logic [23:0] scaled;
		scaled = 24'(value) * 24'(RAW_FULL_MV);
		return is_mv ? value : VAL_W'(scaled / 24'(RAW_FULL_CODE));
	endfunction

	function automatic logic [PCT_W-1:0] moisture_of(input logic [AVG_W-1:0] avg_mv);
		longint m;
		longint t;
		longint q;
		m = longint'(avg_mv);
		t = longint'(coef_sq) * (m * m) + longint'(coef_lin) * m * 4096
			+ longint'(coef_off) * 16777216;
		if (t < 0) begin
			return '0;
		end
		q = t >>> FRAC_SHIFT;
		if (q > longint'(MOIST_FULL)) begin
			q = longint'(MOIST_FULL);
		end
		return q[PCT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t         got;
		reading_t         want;
		logic [VAL_W-1:0] mv;
		logic [AVG_W-1:0] avg;
		logic [PCT_W-1:0] moist;
		if (!arst_n) begin
			fault_low  = FAULT_LOW_RST;
			fault_high = FAULT_HIGH_RST;
			coef_sq    = '0;
			coef_lin   = '0;
			coef_off   = '0;
			safe_low   = '0;
			safe_high  = MOIST_FULL;
			mv_sum     = '0;
			taken      = '0;
			expected_readings.delete();
			readings_pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FAULT_LOW:  fault_low  = cfg_wdata[VAL_W-1:0];
					REG_FAULT_HIGH: fault_high = cfg_wdata[VAL_W-1:0];
					REG_COEF_SQ:    coef_sq    = cfg_wdata[COEF_W-1:0];
					REG_COEF_LIN:   coef_lin   = cfg_wdata[COEF_W-1:0];
					REG_COEF_OFF:   coef_off   = cfg_wdata[OFF_W-1:0];
					REG_SAFE_LOW:   safe_low   = cfg_wdata[PCT_W-1:0];
					REG_SAFE_HIGH:  safe_high  = cfg_wdata[PCT_W-1:0];
					default: ;
				endcase
			end

			if (reading_mon.valid && reading_mon.ready) begin
				got.fault          = reading_mon.fault;
				got.average_mv     = reading_mon.average_mv;
				got.moisture_pct   = reading_mon.moisture_pct;
				got.in_safe_window = reading_mon.in_safe_window;
				if (expected_readings.size() == 0) begin
					mismatches++;
					$error("unexpected reading: fault %0d average_mv %0d moisture_pct %0d",
						got.fault, got.average_mv, got.moisture_pct);
				end else begin
					want = expected_readings.pop_front();
					if (got.fault !== want.fault) begin
						mismatches++;
						$error("fault: expected %0d, actual %0d", want.fault, got.fault);
					end
					if (got.average_mv !== want.average_mv) begin
						mismatches++;
						$error("average_mv: expected %0d, actual %0d",
							want.average_mv, got.average_mv);
					end
					if (got.moisture_pct !== want.moisture_pct) begin
						mismatches++;
						$error("moisture_pct: expected %0d, actual %0d",
							want.moisture_pct, got.moisture_pct);
					end
					if (got.in_safe_window !== want.in_safe_window) begin
						mismatches++;
						$error("in_safe_window: expected %0d, actual %0d",
							want.in_safe_window, got.in_safe_window);
					end
				end
			end

			if (sample_mon.valid && sample_mon.ready) begin
				if (sample_mon.read_failed) begin
					mv_sum = '0;
					taken  = '0;
					want.fault          = 1'b1;
					want.average_mv     = '1;
					want.moisture_pct   = '0;
					want.in_safe_window = 1'b0;
					expected_readings.push_back(want);
				end else begin
					mv = sample_mv(sample_mon.sample_value, sample_mon.sample_is_mv);
					mv_sum = mv_sum + SUM_W'(mv);
					if (int'(taken) + 1 < SAMPLES_PER_READING) begin
						taken = taken + 8'd1;
					end else begin
						avg    = AVG_W'(mv_sum / SUM_W'(SAMPLES_PER_READING));
						mv_sum = '0;
						taken  = '0;
						want.average_mv = avg;
						if (avg < AVG_W'(fault_low) || avg > AVG_W'(fault_high)) begin
							want.fault          = 1'b1;
							want.moisture_pct   = '0;
							want.in_safe_window = 1'b0;
						end else begin
							moist = moisture_of(avg);
							want.fault          = 1'b0;
							want.moisture_pct   = moist;
							want.in_safe_window = (moist >= safe_low) && (moist <= safe_high);
						end
						expected_readings.push_back(want);
					end
				end
			end

			readings_pending <= expected_readings.size();
		end
	end

endmodule

>>> bench/oversampled_quadratic_sensor_calibrator_test.sv
// Testbench top: drives samples and register settings into the calibrator and gives the verdict.
`timescale 1ns / 1ps

module oversampled_quadratic_sensor_calibrator_test;
	import oqsc_pkg::*;

	localparam int SAMPLES       = SAMPLES_DEF;
	localparam int ITEM_TARGET   = 1100;
	localparam int PHASE_ITEMS   = 90;
	localparam int SETTLE_CYCLES = 120;
	localparam int DRAIN_CYCLES  = 200;
	localparam int QUIET_LIMIT   = 5000;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int send_idle_pct = 38;
	int recv_stall_pct = 49;
	int items_sent = 0;
	int quiet_cycles = 0;
	int cur_fault_low = FAULT_LOW_RST;
	int cur_fault_high = FAULT_HIGH_RST;
	int readings_pending;
	int error_count;

	oqsc_sample_if  sample_ch ();
	oqsc_reading_if reading_ch ();

	oversampled_quadratic_sensor_calibrator #(
		.SAMPLES_PER_READING(SAMPLES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample   (sample_ch),
		.reading  (reading_ch)
	);

	oqsc_reading_checker #(
		.SAMPLES_PER_READING(SAMPLES)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.sample_mon      (sample_ch),
		.reading_mon     (reading_ch),
		.readings_pending(readings_pending),
		.error_count     (error_count)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		reading_ch.ready <= (int'($urandom_range(99)) >= recv_stall_pct);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((sample_ch.valid && sample_ch.ready)
			|| (reading_ch.valid && reading_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		@(posedge arst_n);
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int clamp_code(input int v);
		if (v < 0) begin
			return 0;
		end
		if (v > 4095) begin
			return 4095;
		end
		return v;
	endfunction

	function automatic int random_square();
		return int'($urandom_range(120000)) - 60000;
	endfunction

	function automatic int random_linear();
		return int'($urandom_range(140000)) - 70000;
	endfunction

	function automatic int random_offset();
		return int'($urandom_range(50000)) - 20000;
	endfunction

	task automatic push_sample(input int value, input logic is_mv, input logic failed);
		if (items_sent < ITEM_TARGET / 3) begin
			send_idle_pct  = 38;
			recv_stall_pct = 49;
		end else if (items_sent < 2 * ITEM_TARGET / 3) begin
			send_idle_pct  = 49;
			recv_stall_pct = 38;
		end else begin
			send_idle_pct  = 0;
			recv_stall_pct = 0;
		end
		while (int'($urandom_range(99)) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.sample_value <= VAL_W'(value);
		sample_ch.sample_is_mv <= is_mv;
		sample_ch.read_failed  <= failed;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic wait_for_readings();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (readings_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value,
		input int width);
		logic [31:0] mask;
		mask = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= ($urandom() & ~mask) | (value & mask);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_settings(input int fl, input int fh, input int sq, input int lin,
		input int off, input int sl, input int sh);
		write_reg(REG_FAULT_LOW, fl, VAL_W);
		write_reg(REG_FAULT_HIGH, fh, VAL_W);
		write_reg(REG_COEF_SQ, sq, COEF_W);
		write_reg(REG_COEF_LIN, lin, COEF_W);
		write_reg(REG_COEF_OFF, off, OFF_W);
		write_reg(REG_SAFE_LOW, sl, PCT_W);
		write_reg(REG_SAFE_HIGH, sh, PCT_W);
		write_reg(REG_UNUSED, $urandom(), 0);
		cur_fault_low  = fl;
		cur_fault_high = fh;
	endtask

	task automatic configure_phase(input int phase);
		int sl;
		case (phase)
			0: write_settings(0, 4095, 0, 35000, 0, 0, 32767);
			1: write_settings(4095, 0, random_square(), random_linear(), random_offset(),
				0, MOIST_FULL);
			2: write_settings(0, 4095, random_square(), random_linear(), random_offset(),
				20000, 5000);
			3: write_settings(0, 4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h7F_FFFF,
				MOIST_FULL, MOIST_FULL);
			4: write_settings(0, 4095, 32'h8000_0000, 32'h8000_0000, 32'hFF80_0000, 0, 0);
			5: write_settings($urandom_range(4095), $urandom_range(4095), $urandom(),
				$urandom(), $urandom(), $urandom_range(32767), $urandom_range(32767));
			default: begin
				sl = $urandom_range(15000);
				write_settings($urandom_range(600), $urandom_range(4095, 2600),
					random_square(), random_linear(), random_offset(), sl,
					$urandom_range(32767, sl));
			end
		endcase
	endtask

	task automatic send_steady_burst(input int base, input int spread, input int split_at,
		input int mv_mode);
		int v;
		for (int i = 0; i < SAMPLES; i++) begin
			if (i == split_at) begin
				wait_for_readings();
				write_reg(REG_COEF_LIN, random_linear(), COEF_W);
				write_reg(REG_SAFE_HIGH, $urandom_range(32767), PCT_W);
			end
			v = clamp_code(base + int'($urandom_range(2 * spread)) - spread);
			push_sample(v, (mv_mode < 0) ? logic'($urandom_range(1)) : logic'(mv_mode), 1'b0);
		end
	endtask

	task automatic send_broken_burst();
		int good;
		int base;
		good = $urandom_range(SAMPLES - 1);
		base = $urandom_range(4095);
		for (int i = 0; i < good; i++) begin
			push_sample(clamp_code(base + int'($urandom_range(200)) - 100),
				logic'($urandom_range(1)), 1'b0);
		end
		push_sample($urandom_range(4095), logic'($urandom_range(1)), 1'b1);
	endtask

	task automatic send_random_burst();
		int pick;
		int base;
		pick = $urandom_range(99);
		base = $urandom_range(4095);
		if (pick < 60) begin
			send_steady_burst(base, $urandom_range(1) ? 4 : 150, -1, -1);
		end else if (pick < 72) begin
			send_steady_burst(2048, 2048, -1, -1);
		end else if (pick < 80) begin
			case ($urandom_range(3))
				0: base = cur_fault_low - 1;
				1: base = cur_fault_low;
				2: base = cur_fault_high;
				default: base = cur_fault_high + 1;
			endcase
			send_steady_burst(clamp_code(base), 0, -1, 1);
		end else if (pick < 86) begin
			send_steady_burst(base, 30, $urandom_range(SAMPLES - 1, 1), -1);
		end else begin
			send_broken_burst();
		end
	endtask

	initial begin
		int phase;
		int phase_end;
		cfg_we                 <= 1'b0;
		cfg_index              <= '0;
		cfg_wdata              <= '0;
		sample_ch.valid        <= 1'b0;
		sample_ch.sample_value <= '0;
		sample_ch.sample_is_mv <= 1'b0;
		sample_ch.read_failed  <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_sample(4095, 1'b1, 1'b1);
		send_steady_burst(4095, 0, -1, 1);
		for (int i = 0; i < 3; i++) begin
			push_sample(0, 1'b0, 1'b0);
		end
		push_sample(4095, 1'b0, 1'b1);
		wait_for_readings();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			configure_phase(phase);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
				send_random_burst();
			end
			wait_for_readings();
			phase++;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
